// File: src/rmq_pkg.sv
// Shared types and constants for the rotation-matrix-to-quaternion pipeline.
// No dependencies; imported by every module of the block.
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int IN_W          = 16;
    // magnitude of a sum or difference of two elements
    localparam int DIFF_W        = 17;

    typedef logic signed [IN_W-1:0] elem_t;

    typedef struct packed {
        logic              neg;
        logic [DIFF_W-1:0] mag;
    } lane_t;

    // where each quaternion component is taken from at the end of the pipe
    typedef enum logic [1:0] {
        SRC_LANE0,
        SRC_LANE1,
        SRC_LANE2,
        SRC_ROOT
    } src_t;

    typedef struct packed {
        src_t qx;
        src_t qy;
        src_t qz;
        src_t qw;
    } route_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    function automatic lane_t to_lane(input logic signed [DIFF_W-1:0] d);
        lane_t l;
        l.neg = d[DIFF_W-1];
        l.mag = d[DIFF_W-1] ? (~d + 1'b1) : d;
        return l;
    endfunction

endpackage

// File: src/rmq_front.sv
// Input stage: trace test, pivot choice, radicand and off-diagonal sums and differences.
// Depends on rmq_pkg.
module rmq_front
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  elem_t                   r00,
    input  elem_t                   r01,
    input  elem_t                   r02,
    input  elem_t                   r10,
    input  elem_t                   r11,
    input  elem_t                   r12,
    input  elem_t                   r20,
    input  elem_t                   r21,
    input  elem_t                   r22,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [FRAC_BITS+17:0]   t,
    output lane_t [2:0]             lanes,
    output route_t                  route
);

    localparam int TW = FRAC_BITS + 19;
    localparam logic signed [TW-1:0] ONE_T = TW'(longint'(1) << FRAC_BITS);

    logic                    vld_reg;
    logic [TW-2:0]           t_reg;
    lane_t [2:0]             lanes_reg;
    route_t                  route_reg;

    logic                    en;
    logic signed [TW-1:0]    tr;
    logic signed [TW-1:0]    rad;
    axis_t                   piv;
    elem_t                   mii;
    elem_t                   mjj;
    elem_t                   mkk;
    lane_t [2:0]             lanes_next;
    route_t                  route_next;

    assign en       = !vld_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        tr = TW'(r00) + TW'(r11) + TW'(r22);

        // lower index wins ties
        piv = AXIS_X;
        if (r11 > r00)
        begin
            piv = AXIS_Y;
        end
        if (r22 > ((piv == AXIS_Y) ? r11 : r00))
        begin
            piv = AXIS_Z;
        end

        mii = r00;
        mjj = r11;
        mkk = r22;
        unique case (piv)
            AXIS_X:
            begin
                mii = r00; mjj = r11; mkk = r22;
                lanes_next[0] = to_lane(DIFF_W'(r21) - DIFF_W'(r12));
                lanes_next[1] = to_lane(DIFF_W'(r10) + DIFF_W'(r01));
                lanes_next[2] = to_lane(DIFF_W'(r20) + DIFF_W'(r02));
                route_next    = '{qx: SRC_ROOT,  qy: SRC_LANE1, qz: SRC_LANE2, qw: SRC_LANE0};
            end
            AXIS_Y:
            begin
                mii = r11; mjj = r22; mkk = r00;
                lanes_next[0] = to_lane(DIFF_W'(r02) - DIFF_W'(r20));
                lanes_next[1] = to_lane(DIFF_W'(r21) + DIFF_W'(r12));
                lanes_next[2] = to_lane(DIFF_W'(r01) + DIFF_W'(r10));
                route_next    = '{qx: SRC_LANE2, qy: SRC_ROOT,  qz: SRC_LANE1, qw: SRC_LANE0};
            end
            default:
            begin
                mii = r22; mjj = r00; mkk = r11;
                lanes_next[0] = to_lane(DIFF_W'(r10) - DIFF_W'(r01));
                lanes_next[1] = to_lane(DIFF_W'(r02) + DIFF_W'(r20));
                lanes_next[2] = to_lane(DIFF_W'(r12) + DIFF_W'(r21));
                route_next    = '{qx: SRC_LANE1, qy: SRC_LANE2, qz: SRC_ROOT,  qw: SRC_LANE0};
            end
        endcase

        rad = TW'(mii) - (TW'(mjj) + TW'(mkk)) + ONE_T;

        if (tr > 0)
        begin
            rad           = tr + ONE_T;
            lanes_next[0] = to_lane(DIFF_W'(r21) - DIFF_W'(r12));
            lanes_next[1] = to_lane(DIFF_W'(r02) - DIFF_W'(r20));
            lanes_next[2] = to_lane(DIFF_W'(r10) - DIFF_W'(r01));
            route_next    = '{qx: SRC_LANE0, qy: SRC_LANE1, qz: SRC_LANE2, qw: SRC_ROOT};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    // negative radicand is taken as zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= rad[TW-1] ? '0 : rad[TW-2:0];
            lanes_reg <= lanes_next;
            route_reg <= route_next;
        end
    end

    assign out_valid = vld_reg;
    assign t         = t_reg;
    assign lanes     = lanes_reg;
    assign route     = route_reg;

endmodule

// File: src/rmq_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on rmq_pkg.
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [FRAC_BITS+17:0]   t,
    input  lane_t [2:0]             lanes_in,
    input  route_t                  route_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [FRAC_BITS+8:0]    root,
    output lane_t [2:0]             lanes_out,
    output route_t                  route_out
);

    localparam int N  = FRAC_BITS + 9;
    localparam int VW = 2 * N;
    localparam int RW = N + 3;

    logic [N-1:0]   vld_reg;
    logic [VW-1:0]  vsh_reg   [N];
    logic [RW-1:0]  rem_reg   [N];
    logic [N-1:0]   root_reg  [N];
    lane_t [2:0]    lane_reg  [N];
    route_t         route_reg [N];

    logic           en;

    assign en       = !vld_reg[N-1] || out_ready;
    assign in_ready = en;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic            vld_in;
        logic [VW-1:0]   vsh_in;
        logic [RW-1:0]   rem_in;
        logic [N-1:0]    root_in;
        lane_t [2:0]     lane_in;
        route_t          rt_in;
        logic [RW-1:0]   rem_sh;
        logic [RW-1:0]   trial;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign vsh_in  = {t, {FRAC_BITS{1'b0}}};
            assign rem_in  = '0;
            assign root_in = '0;
            assign lane_in = lanes_in;
            assign rt_in   = route_in;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign vsh_in  = vsh_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign lane_in = lane_reg[k-1];
            assign rt_in   = route_reg[k-1];
        end

        // bring down the next two radicand bits and try 4*root+1
        assign rem_sh = {rem_in[RW-3:0], vsh_in[VW-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vsh_reg[k]   <= vsh_in << 2;
                rem_reg[k]   <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k]  <= {root_in[N-2:0], ge};
                lane_reg[k]  <= lane_in;
                route_reg[k] <= rt_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign lanes_out = lane_reg[N-1];
    assign route_out = route_reg[N-1];

endmodule

// File: src/rmq_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage:
// quotient = (mag << FRAC_BITS) / (2 * root). Depends on rmq_pkg.
module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [FRAC_BITS+8:0]              root_in,
    input  lane_t [2:0]                       lanes_in,
    input  route_t                            route_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [FRAC_BITS+8:0]              root_out,
    output logic [2:0][DIFF_W+FRAC_BITS-1:0]  quo,
    output logic [2:0]                        neg,
    output route_t                            route_out
);

    localparam int N  = FRAC_BITS + 9;
    localparam int DW = DIFF_W + FRAC_BITS;

    logic [DW-1:0]          vld_reg;
    logic [2:0][DW-1:0]     qd_reg    [DW];
    logic [2:0][N+1:0]      rem_reg   [DW];
    logic [N-1:0]           root_reg  [DW];
    logic [2:0]             neg_reg   [DW];
    route_t                 route_reg [DW];

    logic                   en;

    assign en       = !vld_reg[DW-1] || out_ready;
    assign in_ready = en;

    for (genvar k = 0; k < DW; k++)
    begin : g_stage
        logic                vld_in;
        logic [2:0][DW-1:0]  qd_in;
        logic [2:0][N+1:0]   rem_in;
        logic [N-1:0]        rt_root;
        logic [2:0]          neg_in;
        route_t              rt_in;
        logic [N:0]          dvsr;
        logic [2:0][DW-1:0]  qd_nx;
        logic [2:0][N+1:0]   rem_nx;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rt_root = root_in;
            assign rt_in   = route_in;
            for (genvar l = 0; l < 3; l++)
            begin : g_init
                assign qd_in[l]  = {lanes_in[l].mag, {FRAC_BITS{1'b0}}};
                assign rem_in[l] = '0;
                assign neg_in[l] = lanes_in[l].neg;
            end
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign qd_in   = qd_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign rt_root = root_reg[k-1];
            assign neg_in  = neg_reg[k-1];
            assign rt_in   = route_reg[k-1];
        end

        assign dvsr = {rt_root, 1'b0};

        // shift in the next dividend bit, subtract the divisor where it fits
        always_comb
        begin
            logic [N+1:0] sh;
            logic         ge;
            for (int l = 0; l < 3; l++)
            begin
                sh        = {rem_in[l][N:0], qd_in[l][DW-1]};
                ge        = sh >= {1'b0, dvsr};
                rem_nx[l] = ge ? (sh - {1'b0, dvsr}) : sh;
                qd_nx[l]  = {qd_in[l][DW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qd_reg[k]    <= qd_nx;
                rem_reg[k]   <= rem_nx;
                root_reg[k]  <= rt_root;
                neg_reg[k]   <= neg_in;
                route_reg[k] <= rt_in;
            end
        end
    end

    assign out_valid = vld_reg[DW-1];
    assign root_out  = root_reg[DW-1];
    assign quo       = qd_reg[DW-1];
    assign neg       = neg_reg[DW-1];
    assign route_out = route_reg[DW-1];

endmodule

// File: src/rmq_out.sv
// Output stage: sign, saturation, zero-root handling and component routing,
// into the output register. Depends on rmq_pkg.
module rmq_out
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [FRAC_BITS+8:0]              root,
    input  logic [2:0][DIFF_W+FRAC_BITS-1:0]  quo,
    input  logic [2:0]                        neg,
    input  route_t                            route,
    output logic                              out_valid,
    input  logic                              out_ready,
    output elem_t                             qx,
    output elem_t                             qy,
    output elem_t                             qz,
    output elem_t                             qw
);

    localparam int N  = FRAC_BITS + 9;
    localparam int DW = DIFF_W + FRAC_BITS;
    localparam longint SAT_POS = (FRAC_BITS >= 15) ? 32767 : (longint'(1) << FRAC_BITS);
    localparam longint SAT_NEG = (FRAC_BITS >= 15) ? 32768 : (longint'(1) << FRAC_BITS);

    logic    vld_reg;
    elem_t   qx_reg;
    elem_t   qy_reg;
    elem_t   qz_reg;
    elem_t   qw_reg;

    logic    en;
    elem_t   root_val;
    elem_t   lane_val [3];
    elem_t   qx_next;
    elem_t   qy_next;
    elem_t   qz_next;
    elem_t   qw_next;
    logic [N-1:0] root_half;

    function automatic elem_t sat_lane(input logic [DW-1:0] mag, input logic is_neg);
        elem_t r;
        if (is_neg)
        begin
            r = (mag > DW'(SAT_NEG)) ? IN_W'(-SAT_NEG) : IN_W'(~mag + 1'b1);
        end
        else
        begin
            r = (mag > DW'(SAT_POS)) ? IN_W'(SAT_POS) : IN_W'(mag);
        end
        return r;
    endfunction

    function automatic elem_t pick(input src_t s, input elem_t rv, input elem_t l0,
                                   input elem_t l1, input elem_t l2);
        elem_t r;
        unique case (s)
            SRC_LANE0: r = l0;
            SRC_LANE1: r = l1;
            SRC_LANE2: r = l2;
            default:   r = rv;
        endcase
        return r;
    endfunction

    assign en       = !vld_reg || out_ready;
    assign in_ready = en;

    assign root_half = root >> 1;

    always_comb
    begin
        root_val = (root_half > N'(SAT_POS)) ? IN_W'(SAT_POS) : IN_W'(root_half);
        // zero root clears the three scaled components
        for (int l = 0; l < 3; l++)
        begin
            lane_val[l] = (root == '0) ? '0 : sat_lane(quo[l], neg[l]);
        end
        qx_next = pick(route.qx, root_val, lane_val[0], lane_val[1], lane_val[2]);
        qy_next = pick(route.qy, root_val, lane_val[0], lane_val[1], lane_val[2]);
        qz_next = pick(route.qz, root_val, lane_val[0], lane_val[1], lane_val[2]);
        qw_next = pick(route.qw, root_val, lane_val[0], lane_val[1], lane_val[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            qz_reg <= qz_next;
            qw_reg <= qw_next;
        end
    end

    assign out_valid = vld_reg;
    assign qx        = qx_reg;
    assign qy        = qy_reg;
    assign qz        = qz_reg;
    assign qw        = qw_reg;

endmodule

// File: src/rotation_matrix_to_quaternion_top.sv
// Top level of the rotation-matrix-to-quaternion converter.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div and rmq_out.
//
// Converts a 3x3 rotation matrix in signed fixed point (FRAC_BITS fractional
// bits, Q2.14 by default) into the quaternion (qx, qy, qz, qw) in the same
// format, by Shoemake's method: a positive trace gives qw from the root of
// trace+1, otherwise the largest diagonal element (lowest index on a tie)
// gives its own component from the root. The root is rounded down, the other
// three components are truncated toward zero, a zero root clears them, and
// every result saturates to plus or minus one (to the 16-bit signed range
// when FRAC_BITS is 15 or more). One transaction enters per clock cycle
// while the pipeline does not stall. The pipeline is one register stage for
// the front decode, FRAC_BITS+9 stages of the bit-per-stage square root,
// FRAC_BITS+17 stages of the three-lane bit-per-stage divider, and the
// output register. Each section holds when its last stage is full and the
// next section cannot take it; a stall drops and repeats no transaction.
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  elem_t  r00,
    input  elem_t  r01,
    input  elem_t  r02,
    input  elem_t  r10,
    input  elem_t  r11,
    input  elem_t  r12,
    input  elem_t  r20,
    input  elem_t  r21,
    input  elem_t  r22,
    output logic   out_valid,
    input  logic   out_ready,
    output elem_t  qx,
    output elem_t  qy,
    output elem_t  qz,
    output elem_t  qw
);

    localparam int N  = FRAC_BITS + 9;
    localparam int DW = DIFF_W + FRAC_BITS;

    // front to root
    logic                    fr_valid;
    logic                    fr_ready;
    logic [FRAC_BITS+17:0]   fr_t;
    lane_t [2:0]             fr_lanes;
    route_t                  fr_route;

    // root to divider
    logic                    sq_valid;
    logic                    sq_ready;
    logic [N-1:0]            sq_root;
    lane_t [2:0]             sq_lanes;
    route_t                  sq_route;

    // divider to output
    logic                    dv_valid;
    logic                    dv_ready;
    logic [N-1:0]            dv_root;
    logic [2:0][DW-1:0]      dv_quo;
    logic [2:0]              dv_neg;
    route_t                  dv_route;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .r00       (r00),
        .r01       (r01),
        .r02       (r02),
        .r10       (r10),
        .r11       (r11),
        .r12       (r12),
        .r20       (r20),
        .r21       (r21),
        .r22       (r22),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .t         (fr_t),
        .lanes     (fr_lanes),
        .route     (fr_route)
    );

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .t         (fr_t),
        .lanes_in  (fr_lanes),
        .route_in  (fr_route),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .root      (sq_root),
        .lanes_out (sq_lanes),
        .route_out (sq_route)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .root_in   (sq_root),
        .lanes_in  (sq_lanes),
        .route_in  (sq_route),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .root_out  (dv_root),
        .quo       (dv_quo),
        .neg       (dv_neg),
        .route_out (dv_route)
    );

    rmq_out #(.FRAC_BITS(FRAC_BITS)) u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .root      (dv_root),
        .quo       (dv_quo),
        .neg       (dv_neg),
        .route     (dv_route),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .qx        (qx),
        .qy        (qy),
        .qz        (qz),
        .qw        (qw)
    );

endmodule
